// ===== sv/ggc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_pkg: shared definitions for the greedy graph coloring engine
// Field widths, command codes, parameter defaults and the control word that
// the sequencer sends to the adjacency store.
// ----------------------------------------------------------------------------
package ggc_pkg;

    // Fixed widths of the stream fields
    localparam int VERTEX_W = 5;
    localparam int COLOR_W  = 5;
    localparam int CNT_W    = 6;
    localparam int TAKEN_W  = 2 ** COLOR_W;

    // Most results one color run can return
    localparam int RESULT_CAP = 32;

    // Default matrix size
    localparam int MAX_VERTICES_DEF = 32;

    // Command codes carried in tuser
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_COLOR = 1'b1;

    // Control word from the sequencer to the adjacency store
    typedef struct packed {
        logic ren;    // read the row at raddr
        logic wen;    // write the row at waddr, mark it valid
        logic clear;  // drop every row back to empty
    } adj_ctl_t;

endpackage

// ===== sv/ggc_adj_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_adj_mem: adjacency bit matrix store
// One row per vertex in a synchronous memory with one read and one write
// port. Per-row valid flags make a row that was not written since reset or
// the last clear read as all zero, so a clear only has to reset the flags.
// ----------------------------------------------------------------------------
module ggc_adj_mem
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  adj_ctl_t                ctl,
    input  logic [AW-1:0]           raddr,
    input  logic [AW-1:0]           waddr,
    input  logic [MAX_VERTICES-1:0] wdata,
    output logic [MAX_VERTICES-1:0] rdata
);

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic                    rd_valid_next;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [MAX_VERTICES-1:0] valid_next;

    // Write and read the row array
    always_ff @(posedge aclk) begin
        if (ctl.wen) begin
            adj_mem[waddr] <= wdata;
        end
        if (ctl.ren) begin
            rd_data_reg <= adj_mem[raddr];
        end
    end

    // Track which rows hold data
    always_comb begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (ctl.ren) begin
            rd_valid_next = valid_reg[raddr];
        end
        if (ctl.clear) begin
            valid_next = '0;
        end else if (ctl.wen) begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Empty rows read as no edges
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/ggc_color_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_color_ram: per-vertex color store
// Synchronous memory with one write and one registered read port. Entries
// are written by a run before they are read, so no reset is needed.
// ----------------------------------------------------------------------------
module ggc_color_ram
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic               aclk,
    input  logic               ren,
    input  logic [AW-1:0]      raddr,
    input  logic               wen,
    input  logic [AW-1:0]      waddr,
    input  logic [COLOR_W-1:0] wdata,
    output logic [COLOR_W-1:0] rdata
);

    logic [COLOR_W-1:0] color_mem [MAX_VERTICES];
    logic [COLOR_W-1:0] rd_data_reg;

    // Write and read the color array
    always_ff @(posedge aclk) begin
        if (wen) begin
            color_mem[waddr] <= wdata;
        end
        if (ren) begin
            rd_data_reg <= color_mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ===== sv/ggc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggc_engine: command sequencer and result register
// Loads edges by read-modify-write of two adjacency rows. A color run reads
// row k, walks the colors of lower vertices through the color store, picks
// the first free color, stores it and hands the result to the output word.
// ----------------------------------------------------------------------------
module ggc_engine
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Command side
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    cmd,
    input  logic [VERTEX_W-1:0]     vertex_a,
    input  logic [VERTEX_W-1:0]     vertex_b,
    input  logic [CNT_W-1:0]        n_active,
    // Adjacency store
    output adj_ctl_t                adj_ctl,
    output logic [AW-1:0]           adj_raddr,
    output logic [AW-1:0]           adj_waddr,
    output logic [MAX_VERTICES-1:0] adj_wdata,
    input  logic [MAX_VERTICES-1:0] adj_rdata,
    // Color store
    output logic                    col_ren,
    output logic [AW-1:0]           col_raddr,
    output logic                    col_wen,
    output logic [AW-1:0]           col_waddr,
    output logic [COLOR_W-1:0]      col_wdata,
    input  logic [COLOR_W-1:0]      col_rdata,
    // Result side
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [VERTEX_W-1:0]     m_vertex,
    output logic [COLOR_W-1:0]      m_color,
    output logic                    m_last
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EDGE_A = 7'b0000010,
        ST_EDGE_B = 7'b0000100,
        ST_ROW    = 7'b0001000,
        ST_LOAD   = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_PICK   = 7'b1000000
    } state_t;

    localparam logic [MAX_VERTICES-1:0] ROW_ONE   = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    localparam logic [TAKEN_W-1:0]      TAKEN_ONE = {{(TAKEN_W-1){1'b0}}, 1'b1};

    // Lowest color whose bit is clear; all taken cannot occur
    function automatic logic [COLOR_W-1:0] first_free(input logic [TAKEN_W-1:0] taken);
        logic [COLOR_W-1:0] c;
        c = COLOR_W'(TAKEN_W - 1);
        for (int i = TAKEN_W - 2; i >= 0; i--) begin
            if (!taken[i]) begin
                c = COLOR_W'(i);
            end
        end
        return c;
    endfunction

    state_t                  state_reg, state_next;
    logic [AW-1:0]           a_reg, a_next;
    logic [AW-1:0]           b_reg, b_next;
    logic [VERTEX_W-1:0]     k_reg, k_next;
    logic [VERTEX_W-1:0]     j_reg, j_next;
    logic [MAX_VERTICES-1:0] row_reg, row_next;
    logic [TAKEN_W-1:0]      taken_reg, taken_next;
    logic                    pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0]     out_vertex_reg, out_vertex_next;
    logic [COLOR_W-1:0]      out_color_reg, out_color_next;
    logic                    out_last_reg, out_last_next;

    logic                    edge_ok;
    logic                    is_last;
    logic [COLOR_W-1:0]      pick_color;

    // Edge endpoints must be distinct and inside the active count
    assign edge_ok = ({1'b0, vertex_a} < n_active) && ({1'b0, vertex_b} < n_active)
                     && (vertex_a != vertex_b);
    assign is_last    = (({1'b0, k_reg} + CNT_W'(1)) == n_active);
    assign pick_color = first_free(taken_reg);

    always_comb begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        row_next        = row_reg;
        taken_next      = taken_reg;
        pend_next       = pend_reg;
        out_vertex_next = out_vertex_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        s_tready  = 1'b0;
        adj_ctl   = '0;
        adj_raddr = '0;
        adj_waddr = '0;
        adj_wdata = adj_rdata;
        col_ren   = 1'b0;
        col_raddr = AW'(j_reg);
        col_wen   = 1'b0;
        col_waddr = AW'(k_reg);
        col_wdata = pick_color;

        // Fold in the color returned for the previous scan step
        if (pend_reg) begin
            taken_next = taken_reg | (TAKEN_ONE << col_rdata);
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (cmd == CMD_EDGE) begin
                        if (edge_ok) begin
                            adj_ctl.ren = 1'b1;
                            adj_raddr   = AW'(vertex_a);
                            a_next      = AW'(vertex_a);
                            b_next      = AW'(vertex_b);
                            state_next  = ST_EDGE_A;
                        end
                    end else if (n_active == '0) begin
                        adj_ctl.clear = 1'b1;
                    end else begin
                        k_next     = '0;
                        state_next = ST_ROW;
                    end
                end
            end
            ST_EDGE_A: begin
                // Set bit b in row a, fetch row b
                adj_ctl.wen = 1'b1;
                adj_waddr   = a_reg;
                adj_wdata   = adj_rdata | (ROW_ONE << b_reg);
                adj_ctl.ren = 1'b1;
                adj_raddr   = b_reg;
                state_next  = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                // Set bit a in row b
                adj_ctl.wen = 1'b1;
                adj_waddr   = b_reg;
                adj_wdata   = adj_rdata | (ROW_ONE << a_reg);
                state_next  = ST_IDLE;
            end
            ST_ROW: begin
                adj_ctl.ren = 1'b1;
                adj_raddr   = AW'(k_reg);
                state_next  = ST_LOAD;
            end
            ST_LOAD: begin
                row_next   = adj_rdata;
                j_next     = '0;
                taken_next = '0;
                pend_next  = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // Fetch the color of each lower vertex, keep neighbors only
                if (j_reg != k_reg) begin
                    col_ren   = 1'b1;
                    pend_next = row_reg[AW'(j_reg)];
                    j_next    = j_reg + VERTEX_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                // Store the color and hand the result over once the slot frees
                if (!out_valid_reg || m_ready) begin
                    col_wen         = 1'b1;
                    out_valid_next  = 1'b1;
                    out_vertex_next = k_reg;
                    out_color_next  = pick_color;
                    out_last_next   = is_last;
                    if (is_last) begin
                        adj_ctl.clear = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        k_next     = k_reg + VERTEX_W'(1);
                        state_next = ST_ROW;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        k_reg          <= k_next;
        j_reg          <= j_next;
        row_reg        <= row_next;
        taken_reg      <= taken_next;
        out_vertex_reg <= out_vertex_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_vertex = out_vertex_reg;
    assign m_color  = out_color_reg;
    assign m_last   = out_last_reg;

endmodule

// ===== sv/greedy_graph_coloring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_graph_coloring: first-fit graph coloring over an adjacency matrix
// Edge word: row read, then two row read-modify-writes; no new command is
// taken until both rows are written. An ignored edge or a color word with
// no vertices is handled in the idle state. Color word: for each vertex k,
// a row read, row latch, one color read per lower vertex and a pick;
// a stalled result holds the run in place.
// Reset (aresetn low, synchronous) empties the matrix and sets num_vertices
// to 32; the matrix empties again at the end of every run.
// ----------------------------------------------------------------------------
module greedy_graph_coloring
    import ggc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration
    input  logic         cfg_wr_en,
    input  logic [5:0]   cfg_wr_data,   // num_vertices
    // Command stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,       // [4:0] vertex_a, [9:5] vertex_b, rest zero
    input  logic         s_tuser,       // [0] cmd
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,       // [4:0] vertex, [9:5] color, rest zero
    output logic         m_tlast        // last
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [CNT_W-1:0] N_CAP =
        CNT_W'((MAX_VERTICES < RESULT_CAP) ? MAX_VERTICES : RESULT_CAP);
    localparam logic [CNT_W-1:0] N_RESET = CNT_W'(32);

    logic [CNT_W-1:0]        num_vertices_reg, num_vertices_next;
    logic [CNT_W-1:0]        n_active;

    adj_ctl_t                adj_ctl;
    logic [AW-1:0]           adj_raddr;
    logic [AW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [MAX_VERTICES-1:0] adj_rdata;

    logic                    col_ren;
    logic [AW-1:0]           col_raddr;
    logic                    col_wen;
    logic [AW-1:0]           col_waddr;
    logic [COLOR_W-1:0]      col_wdata;
    logic [COLOR_W-1:0]      col_rdata;

    logic [VERTEX_W-1:0]     m_vertex;
    logic [COLOR_W-1:0]      m_color;

    // Hold the vertex count register
    assign num_vertices_next = cfg_wr_en ? cfg_wr_data : num_vertices_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vertices_reg <= N_RESET;
        end else begin
            num_vertices_reg <= num_vertices_next;
        end
    end

    // Saturate the count to the matrix size and the result limit
    assign n_active = (num_vertices_reg > N_CAP) ? N_CAP : num_vertices_reg;

    ggc_adj_mem #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_adj_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (adj_ctl),
        .raddr   (adj_raddr),
        .waddr   (adj_waddr),
        .wdata   (adj_wdata),
        .rdata   (adj_rdata)
    );

    ggc_color_ram #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_color_ram (
        .aclk  (aclk),
        .ren   (col_ren),
        .raddr (col_raddr),
        .wen   (col_wen),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .rdata (col_rdata)
    );

    ggc_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cmd       (s_tuser),
        .vertex_a  (s_tdata[4:0]),
        .vertex_b  (s_tdata[9:5]),
        .n_active  (n_active),
        .adj_ctl   (adj_ctl),
        .adj_raddr (adj_raddr),
        .adj_waddr (adj_waddr),
        .adj_wdata (adj_wdata),
        .adj_rdata (adj_rdata),
        .col_ren   (col_ren),
        .col_raddr (col_raddr),
        .col_wen   (col_wen),
        .col_waddr (col_waddr),
        .col_wdata (col_wdata),
        .col_rdata (col_rdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_vertex  (m_vertex),
        .m_color   (m_color),
        .m_last    (m_tlast)
    );

    // Pack the result word
    assign m_tdata = {6'b0, m_color, m_vertex};

endmodule
